// ===== rtl/gld_pkg.sv =====
// ----------------------------------------------------------------------------
// GIF LZW decoder package
// Shared sizes, request and status codes, and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package gld_pkg;

	localparam int MAX_CODE_BITS = 12;
	localparam int STACK_DEPTH   = 4096;
	localparam int TABLE_SIZE    = 1 << MAX_CODE_BITS;
	localparam int CODE_W        = MAX_CODE_BITS;
	localparam int NFC_W         = MAX_CODE_BITS + 1;
	localparam int STK_AW        = $clog2(STACK_DEPTH);
	localparam int SP_W          = STK_AW + 1;
	localparam int BUF_W         = 24;
	localparam int CNT_W         = 5;
	localparam int MSZ_W         = 4;
	localparam int CW_W          = 4;
	localparam int PIX_W         = 8;

	localparam logic [MSZ_W-1:0] MSZ_RESET = MSZ_W'(8);
	localparam logic [MSZ_W-1:0] MSZ_MIN   = MSZ_W'(2);
	localparam logic [MSZ_W-1:0] MSZ_MAX   = MSZ_W'(8);

	typedef enum logic [1:0] {
		REQ_START = 2'd0,
		REQ_BYTE  = 2'd1,
		REQ_PIXEL = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_PIXEL   = 3'd0,
		ST_TAKEN   = 3'd1,
		ST_NEED    = 3'd2,
		ST_END     = 3'd3,
		ST_STARTED = 3'd4,
		ST_FULL    = 3'd5
	} status_t;

	typedef struct packed {
		logic    start;
		logic    add_byte;
		logic    take_code;
		logic    clear_tbl;
		logic    first_code;
		logic    set_finished;
		logic    begin_entry;
		logic    walk_step;
		logic    finish_entry;
		logic    pop;
		logic    out_load;
		logic    out_from_stack;
		status_t out_status;
	} gld_cmd_t;

	typedef struct packed {
		logic stack_empty;
		logic finished;
		logic buf_full;
		logic enough_bits;
		logic code_is_clear;
		logic expect_first;
		logic code_ge_clear;
		logic code_bad;
		logic cur_ge_clear;
		logic prefix_ge_clear;
		logic out_free;
	} gld_stat_t;

	function automatic logic [MSZ_W-1:0] clamp_msz(input logic [MSZ_W-1:0] v);
		logic [MSZ_W-1:0] r;
		r = v;
		if (v < MSZ_MIN) r = MSZ_MIN;
		if (v > MSZ_MAX) r = MSZ_MAX;
		return r;
	endfunction

endpackage

// ===== rtl/gld_ram.sv =====
// ----------------------------------------------------------------------------
// GIF LZW decoder generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module gld_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/gld_dpath.sv =====
// ----------------------------------------------------------------------------
// GIF LZW decoder datapath
// Bit buffer, code tables, pixel stack, width tracking and the output register.
// ----------------------------------------------------------------------------
module gld_dpath import gld_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [MSZ_W-1:0]   cfg_wr_data,
	input  logic [7:0]         data_byte,
	input  gld_cmd_t           cmd,
	output gld_stat_t          stat,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [PIX_W-1:0]   pixel_index,
	output logic [2:0]         status
);

	logic [MSZ_W-1:0]  msz_q;
	logic [NFC_W-1:0]  clear_q;
	logic [CW_W-1:0]   cw_q;
	logic [NFC_W-1:0]  nfc_q;
	logic [NFC_W-1:0]  wl_q;
	logic [PIX_W-1:0]  fc_q;
	logic [CODE_W-1:0] prev_q;
	logic [CODE_W-1:0] incode_q;
	logic [CODE_W-1:0] cur_q;
	logic              expect_q;
	logic              fin_q;
	logic [SP_W-1:0]   sp_q;
	logic [BUF_W-1:0]  buf_q;
	logic [CNT_W-1:0]  bcnt_q;
	logic [PIX_W-1:0]  pix_q;
	logic              out_valid_q;
	logic [PIX_W-1:0]  out_pix_q;
	logic [2:0]        out_st_q;

	logic [MSZ_W-1:0]  msz_c;
	logic [NFC_W-1:0]  clear_n;
	logic [BUF_W-1:0]  code_mask;
	logic [BUF_W-1:0]  code_full;
	logic [CODE_W-1:0] code;
	logic [NFC_W-1:0]  code13;
	logic [CODE_W-1:0] cur_sel;
	logic [NFC_W-1:0]  nfc_inc;
	logic [CODE_W-1:0] prefix_rd;
	logic [PIX_W-1:0]  suffix_rd;
	logic [PIX_W-1:0]  stack_rd;
	logic              tab_re;
	logic [CODE_W-1:0] tab_raddr;
	logic              tab_we;
	logic              push_en;
	logic [PIX_W-1:0]  push_data;
	logic              stk_we;
	logic [STK_AW-1:0] stk_raddr;
	logic [SP_W-1:0]   sp_dec;

	assign msz_c     = clamp_msz(msz_q);
	assign clear_n   = NFC_W'(1) << msz_c;
	assign code_mask = ~({BUF_W{1'b1}} << cw_q);
	assign code_full = buf_q & code_mask;
	assign code      = code_full[CODE_W-1:0];
	assign code13    = {1'b0, code};
	assign cur_sel   = (code13 == nfc_q) ? prev_q : code;
	assign nfc_inc   = nfc_q + NFC_W'(1);
	assign sp_dec    = sp_q - SP_W'(1);
	assign stk_raddr = sp_dec[STK_AW-1:0];

	assign stat.stack_empty     = (sp_q == '0);
	assign stat.finished        = fin_q;
	assign stat.buf_full        = ({1'b0, bcnt_q} + 6'd8) > 6'd24;
	assign stat.enough_bits     = ({1'b0, bcnt_q} >= {2'b00, cw_q});
	assign stat.code_is_clear   = (code13 == clear_q);
	assign stat.expect_first    = expect_q;
	assign stat.code_ge_clear   = (code13 >= clear_q);
	assign stat.code_bad        = (code13 == clear_q + NFC_W'(1)) || (code13 > nfc_q);
	assign stat.cur_ge_clear    = ({1'b0, cur_sel} >= clear_q);
	assign stat.prefix_ge_clear = ({1'b0, prefix_rd} >= clear_q);
	assign stat.out_free        = !out_valid_q || !out_stall;

	assign tab_re    = (cmd.begin_entry && stat.cur_ge_clear)
	                 || (cmd.walk_step && stat.prefix_ge_clear);
	assign tab_raddr = cmd.begin_entry ? cur_sel : prefix_rd;
	assign tab_we    = cmd.finish_entry && (nfc_q < NFC_W'(TABLE_SIZE));

	always_comb begin
		push_en   = 1'b0;
		push_data = fc_q;
		if (cmd.begin_entry && (code13 == nfc_q)) begin
			push_en   = 1'b1;
			push_data = fc_q;
		end else if (cmd.walk_step) begin
			push_en   = 1'b1;
			push_data = suffix_rd;
		end else if (cmd.finish_entry) begin
			push_en   = 1'b1;
			push_data = cur_q[PIX_W-1:0];
		end
	end

	assign stk_we = push_en && (sp_q < SP_W'(STACK_DEPTH));

	gld_ram #(.WIDTH(CODE_W), .DEPTH(TABLE_SIZE)) u_prefix (
		.clk   (clk),
		.we    (tab_we),
		.waddr (nfc_q[CODE_W-1:0]),
		.wdata (prev_q),
		.re    (tab_re),
		.raddr (tab_raddr),
		.rdata (prefix_rd)
	);

	gld_ram #(.WIDTH(PIX_W), .DEPTH(TABLE_SIZE)) u_suffix (
		.clk   (clk),
		.we    (tab_we),
		.waddr (nfc_q[CODE_W-1:0]),
		.wdata (cur_q[PIX_W-1:0]),
		.re    (tab_re),
		.raddr (tab_raddr),
		.rdata (suffix_rd)
	);

	gld_ram #(.WIDTH(PIX_W), .DEPTH(STACK_DEPTH)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (sp_q[STK_AW-1:0]),
		.wdata (push_data),
		.re    (cmd.pop),
		.raddr (stk_raddr),
		.rdata (stack_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msz_q       <= MSZ_RESET;
			clear_q     <= NFC_W'(256);
			cw_q        <= CW_W'(9);
			nfc_q       <= NFC_W'(258);
			wl_q        <= NFC_W'(512);
			fc_q        <= '0;
			prev_q      <= '0;
			incode_q    <= '0;
			cur_q       <= '0;
			expect_q    <= 1'b1;
			fin_q       <= 1'b0;
			sp_q        <= '0;
			buf_q       <= '0;
			bcnt_q      <= '0;
			pix_q       <= '0;
			out_valid_q <= 1'b0;
			out_pix_q   <= '0;
			out_st_q    <= '0;
		end else begin
			if (cfg_wr_en) begin
				msz_q <= cfg_wr_data;
			end
			if (cmd.start || cmd.clear_tbl) begin
				clear_q  <= clear_n;
				cw_q     <= CW_W'(msz_c) + CW_W'(1);
				nfc_q    <= clear_n + NFC_W'(2);
				wl_q     <= clear_n << 1;
				expect_q <= 1'b1;
			end
			if (cmd.start) begin
				sp_q   <= '0;
				buf_q  <= '0;
				bcnt_q <= '0;
				fc_q   <= '0;
				prev_q <= '0;
				fin_q  <= 1'b0;
			end
			if (cmd.add_byte) begin
				buf_q  <= buf_q | (BUF_W'(data_byte) << bcnt_q);
				bcnt_q <= bcnt_q + CNT_W'(8);
			end
			if (cmd.take_code) begin
				buf_q  <= buf_q >> cw_q;
				bcnt_q <= bcnt_q - CNT_W'(cw_q);
			end
			if (cmd.first_code) begin
				expect_q <= 1'b0;
				fc_q     <= code[PIX_W-1:0];
				prev_q   <= code;
				pix_q    <= code[PIX_W-1:0];
			end
			if (cmd.set_finished) begin
				fin_q <= 1'b1;
			end
			if (cmd.begin_entry) begin
				incode_q <= code;
				cur_q    <= cur_sel;
			end
			if (cmd.walk_step) begin
				cur_q <= prefix_rd;
			end
			if (stk_we) begin
				sp_q <= sp_q + SP_W'(1);
			end
			if (cmd.pop) begin
				sp_q <= sp_dec;
			end
			if (cmd.finish_entry) begin
				fc_q   <= cur_q[PIX_W-1:0];
				prev_q <= incode_q;
				if (tab_we) begin
					nfc_q <= nfc_inc;
					if ((nfc_inc >= wl_q) && (wl_q < NFC_W'(TABLE_SIZE))) begin
						wl_q <= wl_q << 1;
						cw_q <= cw_q + CW_W'(1);
					end
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
				out_st_q    <= cmd.out_status;
				if (cmd.out_from_stack) begin
					out_pix_q <= stack_rd;
				end else if (cmd.out_status == ST_PIXEL) begin
					out_pix_q <= pix_q;
				end else begin
					out_pix_q <= '0;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_index = out_pix_q;
	assign status      = out_st_q;

endmodule

// ===== rtl/gld_ctrl.sv =====
// ----------------------------------------------------------------------------
// GIF LZW decoder controller
// Sequences requests, code unpacking, the prefix chain walk and stack pops.
// ----------------------------------------------------------------------------
module gld_ctrl import gld_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] req_type,
	input  gld_stat_t  stat,
	output gld_cmd_t   cmd
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_CODE = 7'b0000010,
		S_WALK = 7'b0000100,
		S_FIN  = 7'b0001000,
		S_POP  = 7'b0010000,
		S_POPD = 7'b0100000,
		S_RESP = 7'b1000000
	} state_t;

	state_t  state_q, state_n;
	status_t st_q, st_n;
	req_t    req;
	logic    accept;

	assign req      = req_t'(req_type);
	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && (state_q == S_IDLE);

	always_comb begin
		state_n = state_q;
		st_n    = st_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (req)
						REQ_START: begin
							cmd.start = 1'b1;
							st_n      = ST_STARTED;
							state_n   = S_RESP;
						end
						REQ_BYTE: begin
							if (stat.buf_full) begin
								st_n = ST_FULL;
							end else begin
								cmd.add_byte = 1'b1;
								st_n         = ST_TAKEN;
							end
							state_n = S_RESP;
						end
						REQ_PIXEL: begin
							if (!stat.stack_empty) begin
								cmd.pop = 1'b1;
								state_n = S_POPD;
							end else if (stat.finished) begin
								st_n    = ST_END;
								state_n = S_RESP;
							end else begin
								state_n = S_CODE;
							end
						end
						default: begin
							st_n    = ST_END;
							state_n = S_RESP;
						end
					endcase
				end
			end
			S_CODE: begin
				if (!stat.enough_bits) begin
					st_n    = ST_NEED;
					state_n = S_RESP;
				end else begin
					cmd.take_code = 1'b1;
					if (stat.code_is_clear) begin
						cmd.clear_tbl = 1'b1;
					end else if (stat.expect_first) begin
						if (stat.code_ge_clear) begin
							cmd.set_finished = 1'b1;
							st_n             = ST_END;
						end else begin
							cmd.first_code = 1'b1;
							st_n           = ST_PIXEL;
						end
						state_n = S_RESP;
					end else if (stat.code_bad) begin
						cmd.set_finished = 1'b1;
						st_n             = ST_END;
						state_n          = S_RESP;
					end else begin
						cmd.begin_entry = 1'b1;
						state_n         = stat.cur_ge_clear ? S_WALK : S_FIN;
					end
				end
			end
			S_WALK: begin
				cmd.walk_step = 1'b1;
				if (!stat.prefix_ge_clear) begin
					state_n = S_FIN;
				end
			end
			S_FIN: begin
				cmd.finish_entry = 1'b1;
				state_n          = S_POP;
			end
			S_POP: begin
				cmd.pop = 1'b1;
				state_n = S_POPD;
			end
			S_POPD: begin
				if (stat.out_free) begin
					cmd.out_load       = 1'b1;
					cmd.out_from_stack = 1'b1;
					cmd.out_status     = ST_PIXEL;
					state_n            = S_IDLE;
				end
			end
			S_RESP: begin
				if (stat.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_status = st_q;
					state_n        = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q    <= ST_END;
		end else begin
			state_q <= state_n;
			st_q    <= st_n;
		end
	end

endmodule

// ===== rtl/gif_lzw_decoder.sv =====
// ----------------------------------------------------------------------------
// GIF LZW decoder
// Start, byte and unknown requests pass the response state, stack pops the pop-data
// state; a first code, an end code or too few bits the code and response states; a code
// adding a table entry the code state, a walk step per non-root prefix node, then the
// finish, pop and pop-data states. A clear code read first repeats the code state, and
// output stalls hold the beat. One request is in flight; the next is accepted once the
// beat is presented. Reset is asynchronous, sets the code size to 8 and acts as a start.
// ----------------------------------------------------------------------------
module gif_lzw_decoder import gld_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [MSZ_W-1:0] cfg_wr_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       req_type,
	input  logic [7:0]       data_byte,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [PIX_W-1:0] pixel_index,
	output logic [2:0]       status
);

	gld_cmd_t  cmd;
	gld_stat_t stat;

	gld_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.req_type (req_type),
		.stat     (stat),
		.cmd      (cmd)
	);

	gld_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.data_byte   (data_byte),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_index (pixel_index),
		.status      (status)
	);

endmodule

// ===== tb/gif_lzw_decoder_test.sv =====
// ----------------------------------------------------------------------------
// GIF LZW decoder testbench
// Encodes random images into GIF LZW byte streams and feeds them to the decoder
// as mixed byte and pixel requests. An in-bench predictor works out every
// status and pixel beat, and a checker compares them in order. Random bursts
// of idle and stall cycles fall on both channels, except in the last part.
// ----------------------------------------------------------------------------
module gif_lzw_decoder_test;
	import gld_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [7:0] pix;
		status_t    st;
	} beat_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_wr_en = 1'b0;
	logic [MSZ_W-1:0] cfg_wr_data = '0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [1:0]       req_type = REQ_NONE;
	logic [7:0]       data_byte = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [PIX_W-1:0] pixel_index;
	logic [2:0]       status;

	gif_lzw_decoder DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .data_byte(data_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.pixel_index(pixel_index), .status(status)
	);

	always #6 clk = ~clk;

	beat_t pending_beats[$];
	int    mismatch_cnt = 0;
	int    items_sent = 0;
	int    quiet_cycles = 0;
	bit    calm = 1'b0;

	// Decoder state as predicted.
	logic [11:0] dec_prefix[TABLE_SIZE];
	logic [7:0]  dec_suffix[TABLE_SIZE];
	logic [7:0]  dec_stack[STACK_DEPTH];
	logic [23:0] dec_buf;
	logic [3:0]  dec_msz = 4'd8;
	int dec_sp, dec_bits, dec_width, dec_free, dec_limit, dec_first, dec_prev, dec_clear;
	bit dec_want_first, dec_done;

	function automatic void table_init();
		int s;
		s = dec_msz;
		if (s < 2) s = 2;
		if (s > 8) s = 8;
		dec_clear = 1 << s;
		dec_width = s + 1;
		dec_free = dec_clear + 2;
		dec_limit = 2 * dec_clear;
		for (int i = 0; i < dec_clear; i++) begin
			dec_prefix[i] = '0;
			dec_suffix[i] = i[7:0];
		end
		dec_want_first = 1'b1;
	endfunction

	function automatic void image_init();
		table_init();
		dec_sp = 0;
		dec_buf = '0;
		dec_bits = 0;
		dec_first = 0;
		dec_prev = 0;
		dec_done = 1'b0;
	endfunction

	function automatic void stack_push(int v);
		if (dec_sp < STACK_DEPTH) begin
			dec_stack[dec_sp] = v[7:0];
			dec_sp++;
		end
	endfunction

	function automatic status_t decode_code(output logic [7:0] px);
		int code, incode, guard;
		forever begin
			if (dec_bits < dec_width) return ST_NEED;
			code = dec_buf & ((1 << dec_width) - 1);
			dec_buf = dec_buf >> dec_width;
			dec_bits -= dec_width;
			if (code == dec_clear) begin
				table_init();
				continue;
			end
			if (dec_want_first) begin
				if (code >= dec_clear) begin
					dec_done = 1'b1;
					return ST_END;
				end
				dec_want_first = 1'b0;
				dec_first = code;
				dec_prev = code;
				px = code[7:0];
				return ST_PIXEL;
			end
			if (code == dec_clear + 1 || code > dec_free) begin
				dec_done = 1'b1;
				return ST_END;
			end
			incode = code;
			if (code == dec_free) begin
				stack_push(dec_first);
				code = dec_prev;
			end
			guard = 0;
			while (code >= dec_clear && guard < TABLE_SIZE) begin
				stack_push(dec_suffix[code % TABLE_SIZE]);
				code = dec_prefix[code % TABLE_SIZE];
				guard++;
			end
			dec_first = dec_suffix[code % TABLE_SIZE];
			stack_push(dec_first);
			if (dec_free < TABLE_SIZE) begin
				dec_prefix[dec_free] = dec_prev[11:0];
				dec_suffix[dec_free] = dec_first[7:0];
				dec_free++;
				if (dec_free >= dec_limit && dec_limit < TABLE_SIZE) begin
					dec_limit *= 2;
					dec_width++;
				end
			end
			dec_prev = incode;
			if (dec_sp > 0) begin
				dec_sp--;
				px = dec_stack[dec_sp];
				return ST_PIXEL;
			end
		end
	endfunction

	function automatic status_t predict_request(logic [1:0] r, logic [7:0] b,
			output logic [7:0] px);
		px = '0;
		case (r)
			REQ_START: begin
				image_init();
				return ST_STARTED;
			end
			REQ_BYTE: begin
				if (dec_bits + 8 > 24) return ST_FULL;
				dec_buf = dec_buf | (24'(b) << dec_bits);
				dec_bits += 8;
				return ST_TAKEN;
			end
			REQ_PIXEL: begin
				if (dec_sp > 0) begin
					dec_sp--;
					px = dec_stack[dec_sp];
					return ST_PIXEL;
				end
				if (dec_done) return ST_END;
				return decode_code(px);
			end
			default: return ST_END;
		endcase
	endfunction

	// Result checker.
	always @(posedge clk) begin
		beat_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_beats.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("unexpected beat: pixel %0d status %0d", pixel_index, status);
			end else begin
				e = pending_beats.pop_front();
				if (status !== e.st || pixel_index !== e.pix) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("beat mismatch: expected pixel %0d status %0d, got pixel %0d status %0d",
							e.pix, e.st, pixel_index, status);
				end
			end
		end
	end

	// Receiver stall bursts.
	always @(negedge clk) begin
		int run;
		if (calm) begin
			out_stall <= 1'b0;
		end else if (run > 0) begin
			run--;
		end else begin
			run = $urandom_range(0, 10);
			out_stall <= ($urandom_range(0, 3) == 0);
		end
	end

	// Watchdog on cycles with no accepted beat.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles > 20000) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	task automatic send_request(input logic [1:0] r, input logic [7:0] b,
			output status_t st);
		beat_t e;
		int gap;
		if (!calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 11);
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_type = r;
		data_byte = b;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		e.st = predict_request(r, b, e.pix);
		st = e.st;
		pending_beats.push_back(e);
		items_sent++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic drain_results();
		while (pending_beats.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_min_size(input logic [3:0] v);
		drain_results();
		cfg_wr_data = v;
		cfg_wr_en = 1'b1;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		dec_msz = v;
	endtask

	// Stream encoder.
	logic [7:0] stream_bytes[$];
	int          enc_dict[int];
	logic [31:0] enc_acc;
	int enc_acc_n, enc_next, enc_width, enc_dfree, enc_dlimit, enc_clear;
	bit enc_first;

	function automatic void enc_put(int code);
		enc_acc = enc_acc | (32'(code) << enc_acc_n);
		enc_acc_n += enc_width;
		while (enc_acc_n >= 8) begin
			stream_bytes.push_back(enc_acc[7:0]);
			enc_acc = enc_acc >> 8;
			enc_acc_n -= 8;
		end
	endfunction

	function automatic void enc_restart(int msz);
		enc_dict.delete();
		enc_clear = 1 << msz;
		enc_next = enc_clear + 2;
		enc_width = msz + 1;
		enc_dfree = enc_clear + 2;
		enc_dlimit = 2 * enc_clear;
		enc_first = 1'b1;
	endfunction

	function automatic void enc_emit(int code);
		enc_put(code);
		if (enc_first) begin
			enc_first = 1'b0;
		end else if (enc_dfree < TABLE_SIZE) begin
			enc_dfree++;
			if (enc_dfree >= enc_dlimit && enc_dlimit < TABLE_SIZE) begin
				enc_dlimit *= 2;
				enc_width++;
			end
		end
	endfunction

	function automatic void enc_flush();
		if (enc_acc_n > 0) stream_bytes.push_back(enc_acc[7:0]);
		enc_acc = '0;
		enc_acc_n = 0;
	endfunction

	function automatic void encode_image(int msz, int npix, int colors, int clear_at,
			int clear_reps);
		int w, p, key;
		stream_bytes.delete();
		enc_acc = '0;
		enc_acc_n = 0;
		enc_restart(msz);
		enc_put(enc_clear);
		w = -1;
		for (int i = 0; i < npix; i++) begin
			p = $urandom_range(0, colors - 1);
			if (w < 0) begin
				w = p;
			end else begin
				key = w * 256 + p;
				if (enc_dict.exists(key)) begin
					w = enc_dict[key];
				end else begin
					enc_emit(w);
					if (enc_next < TABLE_SIZE) begin
						enc_dict[key] = enc_next;
						enc_next++;
					end
					w = p;
				end
			end
			if (i == clear_at) begin
				enc_emit(w);
				enc_put(enc_clear);
				enc_restart(msz);
				repeat (clear_reps - 1) enc_put(enc_clear);
				w = -1;
			end
		end
		if (w >= 0) enc_emit(w);
		enc_put(enc_clear + 1);
		enc_flush();
	endfunction

	// Feeds the stream with pixel requests mixed in until the end code or a last need.
	task automatic play_stream(input int extra);
		status_t st;
		st = ST_NEED;
		while (1) begin
			if (stream_bytes.size() != 0 && (st == ST_NEED || $urandom_range(0, 2) == 0)) begin
				send_request(REQ_BYTE, stream_bytes[0], st);
				if (st == ST_TAKEN) void'(stream_bytes.pop_front());
			end else begin
				send_request(REQ_PIXEL, 8'h00, st);
				if (st == ST_END) break;
				if (st == ST_NEED && stream_bytes.size() == 0) break;
			end
		end
		repeat (extra)
			send_request(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)), st);
	endtask

	task automatic test_directed();
		status_t st;
		write_min_size(4'd0);
		send_request(REQ_START, 8'h00, st);
		send_request(REQ_PIXEL, 8'h00, st);
		send_request(REQ_BYTE, 8'h00, st);
		send_request(REQ_BYTE, 8'hFF, st);
		send_request(REQ_BYTE, 8'hA5, st);
		send_request(REQ_BYTE, 8'h5A, st);
		repeat (4) send_request(REQ_PIXEL, 8'h00, st);
		send_request(REQ_NONE, 8'hFF, st);
		write_min_size(4'd15);
		send_request(REQ_START, 8'h00, st);
		send_request(REQ_BYTE, 8'hFF, st);
		send_request(REQ_PIXEL, 8'h00, st);
		send_request(REQ_BYTE, 8'h01, st);
		send_request(REQ_PIXEL, 8'h00, st);
		send_request(REQ_PIXEL, 8'h00, st);
		send_request(REQ_START, 8'h00, st);
		stream_bytes.delete();
		enc_restart(8);
		enc_put(256);
		enc_put(256);
		enc_put(5);
		enc_put(300);
		enc_flush();
		play_stream(1);
		send_request(REQ_START, 8'h00, st);
		stream_bytes.delete();
		enc_restart(8);
		enc_put(257);
		enc_flush();
		play_stream(0);
	endtask

	task automatic run_image(input int msz, input int npix);
		status_t st;
		int colors;
		colors = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 3) : (1 << msz);
		encode_image(msz, npix, colors,
			($urandom_range(0, 3) == 0) ? $urandom_range(0, npix - 1) : -1,
			$urandom_range(1, 3));
		send_request(REQ_START, 8'h00, st);
		play_stream($urandom_range(0, 2));
	endtask

	task automatic test_size_extremes();
		int sizes[4] = '{2, 8, 1, 9};
		foreach (sizes[i]) begin
			write_min_size(4'(sizes[i]));
			run_image((sizes[i] < 2) ? 2 : (sizes[i] > 8) ? 8 : sizes[i], 40);
		end
	endtask

	task automatic test_noise();
		status_t st;
		send_request(REQ_START, 8'h00, st);
		repeat ($urandom_range(10, 30))
			send_request(2'($urandom_range(1, 2)), 8'($urandom_range(0, 255)), st);
	endtask

	task automatic test_random_images(input int target);
		int msz;
		while (items_sent < target) begin
			if ($urandom_range(0, 3) == 0) begin
				msz = $urandom_range(0, 15);
				write_min_size(4'(msz));
			end
			msz = (dec_msz < 2) ? 2 : (dec_msz > 8) ? 8 : dec_msz;
			if ($urandom_range(0, 7) == 0) test_noise();
			else run_image(msz, $urandom_range(5, 60));
		end
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		image_init();
		test_directed();
		test_size_extremes();
		test_random_images(1050);
		calm = 1'b1;
		test_random_images(1250);
		drain_results();
		repeat (40) @(negedge clk);
		if (mismatch_cnt == 0 && pending_beats.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/gld_pkg.sv
rtl/gld_ram.sv
rtl/gld_dpath.sv
rtl/gld_ctrl.sv
rtl/gif_lzw_decoder.sv
tb/gif_lzw_decoder_test.sv
